FILE: sv/lfr_pkg.sv
// Shared constants and types for the LRU frame replacement block.
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W     = FRAME_W;
    localparam int CFG_W      = 5;
    localparam int FAULT_W    = 32;

    localparam int S_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + FRAME_W + 1 + PAGE_BITS + FAULT_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_FRAMES);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // One frame entry as held in the frame memory.
    typedef struct packed {
        page_t page;
        rank_t rank;
    } entry_t;

endpackage

FILE: sv/lru_frame_replacement.sv
// Top level of the LRU frame replacement table with its scan sequencer.
//
//  Channel  | Direction | Handshake         | Contents
//  ---------+-----------+-------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready | page_number
//  m_       | out       | m_tvalid/m_tready | hit, frame_used, evicted_valid,
//           |           |                   | evicted_page, fault_total
//  cfg_     | in        | cfg_wr_en         | frames_in_use
//
//  A reference is handled in two passes over the single frame memory, each covering N
//  entries, N being the active frame count: one read pass finds the match and the
//  victim, one read-modify-write pass re-ranks. The next reference is accepted only once
//  the result has been registered and the sequencer is back in ST_IDLE.
//  Reset clears the valid marks and the fault count and sets the frame count to 16; the
//  frame memory needs no clearing, since an entry is used only once it is valid.
//  A new reference is accepted while a finished result still waits on m_.
`timescale 1ns / 1ps

module lru_frame_replacement (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lfr_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // page_number[19:0], zero fill above
    input  logic [lfr_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit[0], frame_used[4:1], evicted_valid[5], evicted_page[25:6],
    // fault_total[57:26], zero fill above
    output logic [lfr_pkg::M_TDATA_W-1:0]    m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic [lfr_pkg::CFG_W-1:0]      cfg_reg;
    logic [lfr_pkg::MAX_FRAMES-1:0] valid_reg;
    logic [lfr_pkg::FAULT_W-1:0]    fault_reg;

    lfr_pkg::page_t                 page_reg;
    lfr_pkg::count_t                n_reg;
    lfr_pkg::count_t                cnt_reg;
    logic                           rd_v_reg;
    lfr_pkg::frame_t                rd_idx_reg;

    logic                           hit_reg;
    lfr_pkg::frame_t                match_idx_reg;
    lfr_pkg::rank_t                 match_rank_reg;
    logic                           empty_reg;
    lfr_pkg::frame_t                empty_idx_reg;
    logic                           have_best_reg;
    lfr_pkg::frame_t                best_idx_reg;
    lfr_pkg::rank_t                 best_rank_reg;
    lfr_pkg::page_t                 best_page_reg;

    lfr_pkg::frame_t                f_reg;
    lfr_pkg::rank_t                 old_rank_reg;
    logic                           was_valid_reg;
    logic                           ev_reg;

    logic                           m_tvalid_reg;
    logic [lfr_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic [$bits(lfr_pkg::entry_t)-1:0] rd_data;
    lfr_pkg::entry_t                rd_entry;
    lfr_pkg::entry_t                wr_entry;
    logic                           ram_wr_en;
    lfr_pkg::count_t                n_eff;
    logic                           issue;
    logic                           last_rd;
    logic                           row_valid;
    logic                           page_match;

    assign rd_entry = lfr_pkg::entry_t'(rd_data);

    // A count of zero acts as one frame; anything above the table size acts as full.
    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = lfr_pkg::count_t'(1);
        end else if (cfg_reg > lfr_pkg::CFG_W'(lfr_pkg::MAX_FRAMES)) begin
            n_eff = lfr_pkg::count_t'(lfr_pkg::MAX_FRAMES);
        end else begin
            n_eff = lfr_pkg::count_t'(cfg_reg);
        end
    end

    assign issue      = (cnt_reg < n_reg);
    assign last_rd    = rd_v_reg && (lfr_pkg::count_t'(rd_idx_reg) == n_reg - lfr_pkg::count_t'(1));
    assign row_valid  = valid_reg[rd_idx_reg];
    assign page_match = row_valid && (rd_entry.page == page_reg);
    assign ram_wr_en  = (state_reg == ST_UPDATE) && rd_v_reg;

    // Re-rank pass: the chosen frame becomes most recent, the frames it overtakes age.
    always_comb begin
        wr_entry = rd_entry;
        if (rd_idx_reg == f_reg) begin
            wr_entry.page = page_reg;
            wr_entry.rank = '0;
        end else if (row_valid && (!was_valid_reg || rd_entry.rank < old_rank_reg)
                     && rd_entry.rank != '1) begin
            wr_entry.rank = rd_entry.rank + lfr_pkg::rank_t'(1);
        end
    end

    lfr_ram #(
        .WIDTH ($bits(lfr_pkg::entry_t)),
        .DEPTH (lfr_pkg::MAX_FRAMES)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (wr_entry),
        .rd_addr (cnt_reg[lfr_pkg::FRAME_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= lfr_pkg::CFG_RESET;
            valid_reg    <= '0;
            fault_reg    <= '0;
            cnt_reg      <= '0;
            rd_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            // In ST_DONE the result register is handled by the state itself.
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        page_reg      <= s_tdata[lfr_pkg::PAGE_BITS-1:0];
                        n_reg         <= n_eff;
                        cnt_reg       <= '0;
                        rd_v_reg      <= 1'b0;
                        hit_reg       <= 1'b0;
                        empty_reg     <= 1'b0;
                        have_best_reg <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    rd_v_reg   <= issue;
                    rd_idx_reg <= cnt_reg[lfr_pkg::FRAME_W-1:0];
                    if (issue) begin
                        cnt_reg <= cnt_reg + lfr_pkg::count_t'(1);
                    end
                    if (rd_v_reg) begin
                        if (page_match && !hit_reg) begin
                            hit_reg        <= 1'b1;
                            match_idx_reg  <= rd_idx_reg;
                            match_rank_reg <= rd_entry.rank;
                        end
                        if (!row_valid && !empty_reg) begin
                            empty_reg     <= 1'b1;
                            empty_idx_reg <= rd_idx_reg;
                        end
                        // Strictly greater keeps the lowest frame among equal ranks.
                        if (row_valid && (!have_best_reg || rd_entry.rank > best_rank_reg)) begin
                            have_best_reg <= 1'b1;
                            best_idx_reg  <= rd_idx_reg;
                            best_rank_reg <= rd_entry.rank;
                            best_page_reg <= rd_entry.page;
                        end
                    end
                    if (last_rd) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    cnt_reg  <= '0;
                    rd_v_reg <= 1'b0;
                    if (hit_reg) begin
                        f_reg         <= match_idx_reg;
                        old_rank_reg  <= match_rank_reg;
                        was_valid_reg <= 1'b1;
                        ev_reg        <= 1'b0;
                    end else begin
                        if (fault_reg != '1) begin
                            fault_reg <= fault_reg + lfr_pkg::FAULT_W'(1);
                        end
                        if (empty_reg) begin
                            f_reg         <= empty_idx_reg;
                            old_rank_reg  <= '0;
                            was_valid_reg <= 1'b0;
                            ev_reg        <= 1'b0;
                        end else begin
                            f_reg         <= best_idx_reg;
                            old_rank_reg  <= best_rank_reg;
                            was_valid_reg <= 1'b1;
                            ev_reg        <= 1'b1;
                        end
                    end
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    rd_v_reg   <= issue;
                    rd_idx_reg <= cnt_reg[lfr_pkg::FRAME_W-1:0];
                    if (issue) begin
                        cnt_reg <= cnt_reg + lfr_pkg::count_t'(1);
                    end
                    if (last_rd) begin
                        valid_reg[f_reg] <= 1'b1;
                        state_reg        <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Wait here only while the previous result has not been taken.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= lfr_pkg::M_TDATA_W'({
                            fault_reg,
                            ev_reg ? best_page_reg : lfr_pkg::page_t'(0),
                            ev_reg,
                            f_reg,
                            hit_reg
                        });
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/lfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
